FILE: design/nfpa_pkg.sv
package nfpa_pkg;

	localparam int PAGES      = 1024;
	localparam int PAGE_BYTES = 4096;
	localparam int PAGE_W     = $clog2(PAGES);
	localparam int OFF_W      = $clog2(PAGE_BYTES);
	localparam int CNT_W      = 11;
	localparam int ADDR_W     = 32;
	localparam int CFG_IDX_W  = 1;

	typedef enum logic [2:0] {
		ST_DONE     = 3'd0,
		ST_NORUN    = 3'd1,
		ST_OFF      = 3'd2,
		ST_NOTTAKEN = 3'd3,
		ST_OUTSIDE  = 3'd4
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_HEAP_BASE  = 1'b0,
		CFG_NEXTFIT_EN = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		ACT_ALLOC = 1'b0,
		ACT_FREE  = 1'b1
	} action_t;

	// Write side of the page store: one port for the bitmap, one for the lengths.
	typedef struct packed {
		logic              taken_we;
		logic [PAGE_W-1:0] taken_addr;
		logic              taken_data;
		logic              len_we;
		logic [PAGE_W-1:0] len_addr;
		logic [CNT_W-1:0]  len_data;
	} nfpa_wr_t;

endpackage

FILE: design/nfpa_req_if.sv
interface nfpa_req_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic [31:0] request_bytes;
	logic [31:0] free_address;

	modport source (output valid, output action, output request_bytes, output free_address,
		input ready);
	modport sink (input valid, input action, input request_bytes, input free_address,
		output ready);
endinterface

FILE: design/nfpa_rsp_if.sv
interface nfpa_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [31:0] start_address;
	logic [10:0] page_count;

	modport source (output valid, output status, output start_address, output page_count,
		input ready);
	modport sink (input valid, input status, input start_address, input page_count,
		output ready);
endinterface

FILE: design/nfpa_store.sv
module nfpa_store (
	input  logic                          clk,
	input  logic [nfpa_pkg::PAGE_W-1:0]   rd_addr,
	input  nfpa_pkg::nfpa_wr_t            wr,
	output logic                          taken_q,
	output logic [nfpa_pkg::CNT_W-1:0]    len_q
);
	import nfpa_pkg::*;

	logic             taken_mem [PAGES];
	logic [CNT_W-1:0] len_mem [PAGES];

	always_ff @(posedge clk) begin
		if (wr.taken_we) begin
			taken_mem[wr.taken_addr] <= wr.taken_data;
		end
		taken_q <= taken_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (wr.len_we) begin
			len_mem[wr.len_addr] <= wr.len_data;
		end
		len_q <= len_mem[rd_addr];
	end

endmodule

FILE: design/next_fit_page_allocator.sv
// Channel  Role    Payload
// req      sink    action, request_bytes, free_address
// rsp      source  status, start_address, page_count
// cfg      write   cfg_we, cfg_index, cfg_data
//
// After reset a clearing pass zeroes the page store; no item is taken then.
// An allocate scans the taken bitmap one page a cycle through the store's read port, then
// marks the run it found; a free reads the stored length and clears the pages released.
// Items that fail a check on acceptance go straight to the response state.
// One item is worked at a time; the result sits in an output register while the next item
// is accepted, and a stalled rsp only holds up the block when a second result is ready.
module next_fit_page_allocator (
	input  logic                              clk,
	input  logic                              arst_n,
	nfpa_req_if.sink                          req,
	nfpa_rsp_if.source                        rsp,
	input  logic                              cfg_we,
	input  logic [nfpa_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [nfpa_pkg::ADDR_W-1:0]       cfg_data
);
	import nfpa_pkg::*;

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_SCAN, S_MARK, S_FREE_RD, S_FREE_CHK, S_FREE_CLR, S_RESP
	} state_t;

	localparam int SUM_W  = ADDR_W + 1;
	localparam int NEED_W = SUM_W - OFF_W;

	state_t              state_q;
	logic [PAGE_W-1:0]   clr_q;
	logic [PAGE_W-1:0]   resume_q;
	logic [CNT_W-1:0]    need_q;
	logic [PAGE_W:0]     iss_q;
	logic [PAGE_W:0]     hi_q;
	logic                phase_q;
	logic [CNT_W-1:0]    run_q;
	logic [PAGE_W-1:0]   first_q;
	logic                chk_vld_s1;
	logic [PAGE_W-1:0]   chk_page_s1;
	logic [PAGE_W-1:0]   page_q;
	logic [CNT_W-1:0]    walk_q;
	logic [CNT_W-1:0]    len_q;
	status_t             res_status_q;
	logic [ADDR_W-1:0]   res_addr_q;
	logic [CNT_W-1:0]    res_count_q;
	logic                rsp_vld_q;
	status_t             rsp_status_q;
	logic [ADDR_W-1:0]   rsp_addr_q;
	logic [CNT_W-1:0]    rsp_count_q;
	logic [ADDR_W-1:0]   heap_base_q;
	logic                enable_q;

	logic [SUM_W-1:0]    bytes_sum;
	logic [NEED_W-1:0]   need_full;
	logic                size_bad;
	logic [SUM_W-1:0]    free_diff;
	logic                free_out;
	logic [PAGE_W-1:0]   free_page;
	logic                issue_more;
	logic [CNT_W-1:0]    run_next;
	logic [CNT_W-1:0]    walk_next;
	logic [PAGE_W:0]     clr_idx;
	logic                clear_last;
	logic [PAGE_W-1:0]   rd_addr;
	nfpa_wr_t            wr;
	logic                taken_rd;
	logic [CNT_W-1:0]    len_rd;

	nfpa_store u_store (
		.clk     (clk),
		.rd_addr (rd_addr),
		.wr      (wr),
		.taken_q (taken_rd),
		.len_q   (len_rd)
	);

	// Page count rounded up, computed one bit wider so it cannot wrap.
	assign bytes_sum = {1'b0, req.request_bytes} + SUM_W'(PAGE_BYTES - 1);
	assign need_full = bytes_sum[SUM_W-1:OFF_W];
	assign size_bad  = (need_full == '0) || (need_full > NEED_W'(PAGES));

	// Free address: a borrow means below the heap; the page index must fall under PAGES.
	assign free_diff = {1'b0, req.free_address} - {1'b0, heap_base_q};
	assign free_out  = free_diff[SUM_W-1] ||
		(free_diff[ADDR_W-1:OFF_W] >= (ADDR_W - OFF_W)'(PAGES));
	assign free_page = free_diff[OFF_W+PAGE_W-1:OFF_W];

	assign issue_more = (iss_q < hi_q);
	assign run_next   = run_q + CNT_W'(1);
	assign walk_next  = walk_q + CNT_W'(1);
	assign clr_idx    = (PAGE_W + 1)'(page_q) + (PAGE_W + 1)'(walk_q);
	assign clear_last = (walk_next == len_q) || (clr_idx == (PAGE_W + 1)'(PAGES - 1));

	assign rd_addr = (state_q == S_SCAN) ? iss_q[PAGE_W-1:0] : page_q;

	always_comb begin
		wr = '0;
		unique case (state_q)
			S_CLEAR: begin
				wr.taken_we   = 1'b1;
				wr.taken_addr = clr_q;
				wr.len_we     = 1'b1;
				wr.len_addr   = clr_q;
			end
			S_MARK: begin
				wr.taken_we   = 1'b1;
				wr.taken_addr = clr_idx[PAGE_W-1:0];
				wr.taken_data = 1'b1;
				wr.len_we     = (walk_q == '0);
				wr.len_addr   = page_q;
				wr.len_data   = need_q;
			end
			S_FREE_CLR: begin
				wr.taken_we   = 1'b1;
				wr.taken_addr = clr_idx[PAGE_W-1:0];
			end
			default: begin
				wr = '0;
			end
		endcase
	end

	assign req.ready         = (state_q == S_IDLE);
	assign rsp.valid         = rsp_vld_q;
	assign rsp.status        = rsp_status_q;
	assign rsp.start_address = rsp_addr_q;
	assign rsp.page_count    = rsp_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			resume_q     <= '0;
			need_q       <= '0;
			iss_q        <= '0;
			hi_q         <= '0;
			phase_q      <= 1'b0;
			run_q        <= '0;
			first_q      <= '0;
			chk_vld_s1   <= 1'b0;
			chk_page_s1  <= '0;
			page_q       <= '0;
			walk_q       <= '0;
			len_q        <= '0;
			res_status_q <= ST_DONE;
			res_addr_q   <= '0;
			res_count_q  <= '0;
			rsp_vld_q    <= 1'b0;
			rsp_status_q <= ST_DONE;
			rsp_addr_q   <= '0;
			rsp_count_q  <= '0;
			heap_base_q  <= 32'h8000_0000;
			enable_q     <= 1'b1;
		end else begin
			if (cfg_we) begin
				unique case (cfg_reg_t'(cfg_index))
					CFG_HEAP_BASE:  heap_base_q <= cfg_data;
					CFG_NEXTFIT_EN: enable_q    <= cfg_data[0];
				endcase
			end

			if (rsp_vld_q && rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end

			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + PAGE_W'(1);
					if (clr_q == PAGE_W'(PAGES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					res_addr_q  <= '0;
					res_count_q <= '0;
					if (req.valid) begin
						if (action_t'(req.action) == ACT_ALLOC) begin
							if (!enable_q) begin
								res_status_q <= ST_OFF;
								state_q      <= S_RESP;
							end else if (size_bad) begin
								res_status_q <= ST_NORUN;
								state_q      <= S_RESP;
							end else begin
								need_q     <= need_full[CNT_W-1:0];
								iss_q      <= {1'b0, resume_q};
								hi_q       <= (PAGE_W + 1)'(PAGES);
								phase_q    <= 1'b0;
								run_q      <= '0;
								chk_vld_s1 <= 1'b0;
								state_q    <= S_SCAN;
							end
						end else begin
							if (free_out) begin
								res_status_q <= ST_OUTSIDE;
								state_q      <= S_RESP;
							end else begin
								page_q  <= free_page;
								state_q <= S_FREE_RD;
							end
						end
					end
				end
				S_SCAN: begin
					// Reads run one page ahead of the check of the bitmap bit.
					if (issue_more) begin
						iss_q       <= iss_q + (PAGE_W + 1)'(1);
						chk_vld_s1  <= 1'b1;
						chk_page_s1 <= iss_q[PAGE_W-1:0];
					end else begin
						chk_vld_s1 <= 1'b0;
					end
					if (chk_vld_s1) begin
						if (!taken_rd) begin
							if (run_q == '0) begin
								first_q <= chk_page_s1;
							end
							run_q <= run_next;
							if (run_next == need_q) begin
								page_q     <= (run_q == '0) ? chk_page_s1 : first_q;
								resume_q   <= chk_page_s1;
								walk_q     <= '0;
								chk_vld_s1 <= 1'b0;
								state_q    <= S_MARK;
							end
						end else begin
							run_q <= '0;
						end
					end else if (!issue_more) begin
						// Upper range exhausted: rescan from page zero; a run never wraps.
						if (!phase_q) begin
							phase_q <= 1'b1;
							iss_q   <= '0;
							hi_q    <= {1'b0, resume_q};
							run_q   <= '0;
						end else begin
							res_status_q <= ST_NORUN;
							state_q      <= S_RESP;
						end
					end
				end
				S_MARK: begin
					walk_q <= walk_next;
					if (walk_next == need_q) begin
						res_status_q <= ST_DONE;
						res_addr_q   <= heap_base_q + (ADDR_W'(page_q) << OFF_W);
						res_count_q  <= need_q;
						state_q      <= S_RESP;
					end
				end
				S_FREE_RD: begin
					state_q <= S_FREE_CHK;
				end
				S_FREE_CHK: begin
					if (!taken_rd) begin
						res_status_q <= ST_NOTTAKEN;
						state_q      <= S_RESP;
					end else if (len_rd == '0) begin
						res_status_q <= ST_DONE;
						state_q      <= S_RESP;
					end else begin
						len_q   <= len_rd;
						walk_q  <= '0;
						state_q <= S_FREE_CLR;
					end
				end
				S_FREE_CLR: begin
					walk_q <= walk_next;
					if (clear_last) begin
						res_status_q <= ST_DONE;
						res_count_q  <= walk_next;
						state_q      <= S_RESP;
					end
				end
				S_RESP: begin
					if (!rsp_vld_q || rsp.ready) begin
						rsp_vld_q    <= 1'b1;
						rsp_status_q <= res_status_q;
						rsp_addr_q   <= res_addr_q;
						rsp_count_q  <= res_count_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: dv/next_fit_page_allocator_test.sv
`timescale 1ns / 100ps

module next_fit_page_allocator_test;
	import nfpa_pkg::*;

	localparam logic [31:0] DEFAULT_BASE = 32'h8000_0000;
	localparam int          STALL_LIMIT  = 8 * (3 * PAGES + 64);
	localparam logic [31:0] HEAP_SPAN    = 32'(PAGES * PAGE_BYTES);

	typedef struct packed {
		status_t          status;
		logic [31:0]      start_address;
		logic [CNT_W-1:0] page_count;
	} page_result_t;

	class page_alloc_scoreboard;
		bit               taken [PAGES];
		bit [CNT_W-1:0]   run_len [PAGES];
		int unsigned      resume;
		logic [31:0]      heap_base;
		bit               enable;
		page_result_t     pending_results[$];
		int unsigned      live_pages[$];
		int               errors;

		function new();
			foreach (taken[i]) begin
				taken[i] = 1'b0;
				run_len[i] = '0;
			end
			resume = 0;
			heap_base = DEFAULT_BASE;
			enable = 1'b1;
			errors = 0;
		endfunction

		function void set_regs(logic [31:0] base, bit en);
			heap_base = base;
			enable = en;
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		// Looks for need free pages in a row within [lo, hi); runs never wrap.
		function bit find_run(int unsigned lo, int unsigned hi, int unsigned need,
			output int unsigned first);
			int unsigned count;
			int unsigned i;
			count = 0;
			first = 0;
			for (i = lo; i < hi && i < PAGES; i++) begin
				if (!taken[i]) begin
					if (count == 0)
						first = i;
					count++;
					if (count == need) begin
						resume = i;
						return 1'b1;
					end
				end else begin
					count = 0;
				end
			end
			return 1'b0;
		endfunction

		function void note_request(action_t act, logic [31:0] bytes, logic [31:0] addr);
			longint unsigned need;
			longint unsigned pg;
			int unsigned     first;
			int unsigned     cleared;
			int unsigned     i;
			bit [CNT_W-1:0]  len;
			bit              found;
			page_result_t    r;
			r.status = ST_DONE;
			r.start_address = '0;
			r.page_count = '0;
			if (act == ACT_ALLOC) begin
				need = ({32'd0, bytes} + 64'(PAGE_BYTES - 1)) / 64'(PAGE_BYTES);
				if (!enable) begin
					r.status = ST_OFF;
				end else if (need == 0 || need > PAGES) begin
					r.status = ST_NORUN;
				end else begin
					found = find_run(resume, PAGES, int'(need), first);
					if (!found)
						found = find_run(0, resume, int'(need), first);
					if (!found) begin
						r.status = ST_NORUN;
					end else begin
						run_len[first] = need[CNT_W-1:0];
						for (i = 0; i < need && first + i < PAGES; i++)
							taken[first + i] = 1'b1;
						r.start_address = heap_base + 32'(first * PAGE_BYTES);
						r.page_count = need[CNT_W-1:0];
						live_pages.push_back(first);
					end
				end
			end else begin
				if (addr < heap_base) begin
					r.status = ST_OUTSIDE;
				end else begin
					pg = (addr - heap_base) / PAGE_BYTES;
					if (pg >= PAGES) begin
						r.status = ST_OUTSIDE;
					end else if (!taken[pg]) begin
						r.status = ST_NOTTAKEN;
					end else begin
						// The stored length is trusted as is, even when zero or left over.
						len = run_len[pg];
						cleared = 0;
						for (i = 0; i < len && pg + i < PAGES; i++) begin
							taken[pg + i] = 1'b0;
							cleared++;
						end
						r.page_count = cleared[CNT_W-1:0];
					end
				end
			end
			pending_results.push_back(r);
		endfunction

		function void check_response(logic [2:0] status, logic [31:0] start_address,
			logic [CNT_W-1:0] page_count);
			page_result_t exp_r;
			if (pending_results.size() == 0) begin
				$error("unexpected item: status %0d start_address %h page_count %0d",
					status, start_address, page_count);
				errors++;
				return;
			end
			exp_r = pending_results.pop_front();
			if (status !== exp_r.status) begin
				$error("status: expected %0d, actual %0d", exp_r.status, status);
				errors++;
			end
			if (start_address !== exp_r.start_address) begin
				$error("start_address: expected %h, actual %h", exp_r.start_address,
					start_address);
				errors++;
			end
			if (page_count !== exp_r.page_count) begin
				$error("page_count: expected %0d, actual %0d", exp_r.page_count, page_count);
				errors++;
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [ADDR_W-1:0]    cfg_data;
	bit                   no_idle;
	int                   quiet_cycles = 0;
	int                   rsp_stall = 0;
	page_alloc_scoreboard sb;

	nfpa_req_if req_bus ();
	nfpa_rsp_if rsp_bus ();

	next_fit_page_allocator u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_bus),
		.rsp       (rsp_bus),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The receiver stalls in random bursts unless idling is off.
	always @(posedge clk) begin
		if (rsp_stall != 0) begin
			rsp_stall--;
			rsp_bus.ready <= 1'b0;
		end else if (!no_idle && $urandom_range(0, 5) == 0) begin
			rsp_stall = $urandom_range(0, 9);
			rsp_bus.ready <= 1'b0;
		end else begin
			rsp_bus.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
				sb.check_response(rsp_bus.status, rsp_bus.start_address,
					rsp_bus.page_count);
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	task automatic send_item(action_t act, logic [31:0] bytes, logic [31:0] addr);
		req_bus.valid <= 1'b1;
		req_bus.action <= act;
		req_bus.request_bytes <= bytes;
		req_bus.free_address <= addr;
		do @(posedge clk); while (req_bus.ready !== 1'b1);
		sb.note_request(act, bytes, addr);
		if (!no_idle && $urandom_range(0, 3) == 0) begin
			req_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
	endtask

	task automatic alloc_bytes(logic [31:0] bytes);
		send_item(ACT_ALLOC, bytes, $urandom());
	endtask

	task automatic free_at(logic [31:0] addr);
		send_item(ACT_FREE, $urandom(), addr);
	endtask

	// Lets every outstanding item come back so the block is idle.
	task automatic drain();
		req_bus.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic write_settings(logic [31:0] base, bit en);
		cfg_we <= 1'b1;
		cfg_index <= CFG_HEAP_BASE;
		cfg_data <= base;
		@(posedge clk);
		cfg_index <= CFG_NEXTFIT_EN;
		cfg_data <= {31'd0, en};
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_regs(base, en);
	endtask

	// Mostly well-formed sizes and frees of live runs, with some noise mixed in.
	task automatic send_random(int unsigned alloc_pct);
		int unsigned pick;
		int unsigned pages;
		int unsigned idx;
		int unsigned pg;
		logic [31:0] bytes;
		logic [31:0] addr;
		logic [31:0] base;
		base = sb.heap_base;
		pick = $urandom_range(0, 99);
		if ($urandom_range(0, 99) < alloc_pct) begin
			if (pick < 70)
				pages = $urandom_range(1, 8);
			else if (pick < 80)
				pages = $urandom_range(9, 128);
			else if (pick < 83)
				pages = $urandom_range(129, PAGES);
			else
				pages = 0;
			if (pages != 0)
				bytes = 32'((pages - 1) * PAGE_BYTES + $urandom_range(1, PAGE_BYTES));
			else if (pick < 88)
				bytes = '0;
			else if (pick < 93)
				bytes = HEAP_SPAN + 32'($urandom_range(1, 1 << 20));
			else
				bytes = $urandom();
			alloc_bytes(bytes);
		end else begin
			if (pick < 65 && sb.live_pages.size() > 0) begin
				idx = $urandom_range(0, sb.live_pages.size() - 1);
				pg = sb.live_pages[idx];
				sb.live_pages.delete(idx);
				addr = base + 32'(pg * PAGE_BYTES);
				if ($urandom_range(0, 3) == 0)
					addr = addr + $urandom_range(0, PAGE_BYTES - 1);
			end else if (pick < 75 && sb.live_pages.size() > 0) begin
				// A page inside a run may carry a zero or left-over length.
				idx = $urandom_range(0, sb.live_pages.size() - 1);
				pg = sb.live_pages[idx] + $urandom_range(1, 3);
				if (pg >= PAGES)
					pg = PAGES - 1;
				addr = base + 32'(pg * PAGE_BYTES);
			end else if (pick < 85) begin
				addr = base + 32'($urandom_range(0, PAGES * PAGE_BYTES - 1));
			end else if (pick < 92) begin
				if ($urandom_range(0, 1) == 0)
					addr = base - $urandom_range(1, 64);
				else
					addr = base + HEAP_SPAN + $urandom_range(0, 64);
			end else begin
				addr = $urandom();
			end
			free_at(addr);
		end
	endtask

	initial begin
		logic [31:0] base;
		bit          en;
		int          items;
		int unsigned alloc_pct;
		sb = new();
		no_idle = 1'b0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_HEAP_BASE;
		cfg_data <= '0;
		req_bus.valid <= 1'b0;
		req_bus.action <= ACT_ALLOC;
		req_bus.request_bytes <= '0;
		req_bus.free_address <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part on the reset settings.
		alloc_bytes(32'd0);
		alloc_bytes(32'd1);
		alloc_bytes(32'(PAGE_BYTES));
		alloc_bytes(32'(PAGE_BYTES + 1));
		alloc_bytes(32'hFFFF_FFFF);
		alloc_bytes(HEAP_SPAN + 32'd1);
		free_at(DEFAULT_BASE - 32'd1);
		free_at(DEFAULT_BASE + HEAP_SPAN);
		free_at(32'hFFFF_FFFF);
		free_at(DEFAULT_BASE + 32'(3 * PAGE_BYTES + 17));
		free_at(DEFAULT_BASE + 32'(2 * PAGE_BYTES + 5));
		free_at(DEFAULT_BASE + 32'(2 * PAGE_BYTES));
		free_at(DEFAULT_BASE);
		free_at(DEFAULT_BASE + 32'(PAGE_BYTES));
		// Fill the heap so the search wraps back to page zero, then empty it.
		alloc_bytes(32'((PAGES - 4) * PAGE_BYTES));
		alloc_bytes(32'(PAGE_BYTES));
		alloc_bytes(32'd1);
		free_at(DEFAULT_BASE);
		free_at(DEFAULT_BASE + 32'(3 * PAGE_BYTES));
		free_at(DEFAULT_BASE + HEAP_SPAN - 32'd1);
		alloc_bytes(HEAP_SPAN);
		free_at(DEFAULT_BASE + 32'((PAGES - 1) * PAGE_BYTES));
		free_at(DEFAULT_BASE);
		drain();
		write_settings(DEFAULT_BASE, 1'b0);
		alloc_bytes(32'd0);
		alloc_bytes(32'(PAGE_BYTES));

		for (int p = 0; p < 6; p++) begin
			drain();
			alloc_pct = 50;
			en = 1'b1;
			case (p)
				0: begin
					base = 32'h0000_0000;
					items = 90;
				end
				1: begin
					base = 32'hFFFF_FFFF;
					items = 40;
				end
				2: begin
					base = $urandom();
					items = 140;
				end
				3: begin
					base = $urandom();
					en = 1'b0;
					items = 30;
				end
				4: begin
					base = DEFAULT_BASE;
					alloc_pct = 75;
					items = 120;
				end
				default: begin
					base = $urandom();
					items = 140;
				end
			endcase
			write_settings(base, en);
			for (int n = 0; n < items; n++) begin
				no_idle = (p == 2 && n < 40) || (p == 5 && n >= items / 2);
				send_random(alloc_pct);
			end
		end

		drain();
		repeat (2 * PAGES + 16) @(posedge clk);
		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
